### src/mhd_pkg.sv
// ----------------------------------------------------------------------------
// mhd_pkg
// Shared constants and payload types of the multichannel hysteresis debounce.
// ----------------------------------------------------------------------------
package mhd_pkg;

	localparam int CHANNELS         = 8;
	localparam int SAMPLES_PER_READ = 2;
	localparam int CONFIRM_COUNT    = 2;
	localparam int SAMPLE_BITS      = 10;

	// fixed field widths
	localparam int CH_W   = 3;
	localparam int DIR_W  = 2;
	localparam int MASK_W = 8;

	// derived widths
	localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SL_W  = $clog2(SAMPLES_PER_READ + 1);
	localparam int CF_W  = $clog2(CONFIRM_COUNT + 1);
	localparam int THR_W = 2 * SAMPLE_BITS;

	localparam logic [SAMPLE_BITS-1:0] MIN_RESET = {SAMPLE_BITS{1'b1}};

	// operation codes
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_THRESH = 1'b1;

	// direction codes
	localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
	localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
	localparam logic [DIR_W-1:0] DIR_BACK = 2'd2;

	// APB register map: register index sits in paddr[REG_SEL_BIT]
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;
	localparam int REG_SEL_BIT = 2;
	localparam logic REG_FRONT = 1'b0;
	localparam logic REG_BACK  = 1'b1;

	typedef struct packed {
		logic                   operation;
		logic [SAMPLE_BITS-1:0] sample;
		logic [CH_W-1:0]        channel;
		logic [SAMPLE_BITS-1:0] low_threshold;
		logic [SAMPLE_BITS-1:0] high_threshold;
		logic [DIR_W-1:0]       direction;
	} in_item_t;

	typedef struct packed {
		logic                   complete;
		logic [CH_W-1:0]        done_channel;
		logic [SAMPLE_BITS-1:0] raw_min;
		logic                   detected;
		logic                   path_blocked;
		logic [CH_W-1:0]        next_channel;
	} out_item_t;

endpackage

### src/multichannel_hysteresis_debounce.sv
// ----------------------------------------------------------------------------
// multichannel_hysteresis_debounce
// Round-robin min-of-N sensor scan with per-channel hysteresis and debounce.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transfer per ADC sample (operation OP_SAMPLE) or per
//           threshold load (OP_THRESH). Threshold loads give no result.
//   out_* : one transfer per sample; next_channel tells the ADC sequencer
//           which channel to convert next.
//   APB   : front_mask at 0x0, back_mask at 0x4; write only while idle.
// Timing:
//   A sample transfer loads the judge stage and starts the RAM reads of its
//   channel; when that stage advances, it judges the item and loads the
//   output register, which drives out_valid. One item per cycle sustained
//   while out_stall is low; the confirm-counter read-modify-write is
//   covered by forwarding from the write-back to the next read.
// Reset:
//   Scan restarts at channel 0, held states clear, masks clear. RAM entries
//   carry valid flags so unwritten thresholds read 0 and counters read
//   CONFIRM_COUNT; no clearing pass is needed.
// Stall:
//   out_stall holds the output register; the judge stage then holds too and
//   in_stall rises, so nothing is dropped and no state is updated twice.
// ----------------------------------------------------------------------------
module multichannel_hysteresis_debounce (
	input  logic                                 clk,
	input  logic                                 arst_n,

	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  mhd_pkg::in_item_t                    in_data,

	output logic                                 out_valid,
	input  logic                                 out_stall,
	output mhd_pkg::out_item_t                   out_data,

	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [mhd_pkg::PADDR_W-1:0]          paddr,
	input  logic [mhd_pkg::PDATA_W-1:0]          pwdata,
	output logic [mhd_pkg::PDATA_W-1:0]          prdata,
	output logic                                 pready
);

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [mhd_pkg::MASK_W-1:0] front_mask_q;
	logic [mhd_pkg::MASK_W-1:0] back_mask_q;
	logic                       cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_mask_q <= '0;
			back_mask_q  <= '0;
		end else if (cfg_we) begin
			if (paddr[mhd_pkg::REG_SEL_BIT] == mhd_pkg::REG_BACK) begin
				back_mask_q <= pwdata[mhd_pkg::MASK_W-1:0];
			end else begin
				front_mask_q <= pwdata[mhd_pkg::MASK_W-1:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[mhd_pkg::REG_SEL_BIT] == mhd_pkg::REG_BACK) begin
			prdata[mhd_pkg::MASK_W-1:0] = back_mask_q;
		end else begin
			prdata[mhd_pkg::MASK_W-1:0] = front_mask_q;
		end
	end

	// ------------------------------------------------------------------
	// handshake and stage-0 decode
	// ------------------------------------------------------------------
	logic in_acc;
	logic smp_acc;
	logic thr_we;
	logic ch_ok;
	logic s1_vld_q;
	logic s1_adv;
	logic out_vld_q;

	assign s1_adv   = s1_vld_q && (!out_vld_q || !out_stall);
	assign in_stall = s1_vld_q && !s1_adv;
	assign in_acc   = in_valid && !in_stall;
	assign smp_acc  = in_acc && (in_data.operation == mhd_pkg::OP_SAMPLE);
	// writes to channels beyond the configured count are dropped
	assign ch_ok    = {1'b0, in_data.channel} < (mhd_pkg::CH_W + 1)'(mhd_pkg::CHANNELS);
	assign thr_we   = in_acc && (in_data.operation == mhd_pkg::OP_THRESH) && ch_ok;

	// ------------------------------------------------------------------
	// scan sequencer and running minimum
	// ------------------------------------------------------------------
	logic [mhd_pkg::CH_AW-1:0]       scan_q;
	logic [mhd_pkg::CH_AW-1:0]       scan_nxt;
	logic [mhd_pkg::SL_W-1:0]        samples_left_q;
	logic [mhd_pkg::SAMPLE_BITS-1:0] run_min_q;
	logic [mhd_pkg::SAMPLE_BITS-1:0] min_new;
	logic                            last_smp;

	assign min_new  = (in_data.sample < run_min_q) ? in_data.sample : run_min_q;
	assign last_smp = samples_left_q <= mhd_pkg::SL_W'(1);
	assign scan_nxt = (scan_q == mhd_pkg::CH_AW'(mhd_pkg::CHANNELS - 1)) ? '0
	                  : scan_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q         <= '0;
			samples_left_q <= mhd_pkg::SL_W'(mhd_pkg::SAMPLES_PER_READ);
			run_min_q      <= mhd_pkg::MIN_RESET;
		end else if (smp_acc) begin
			if (last_smp) begin
				scan_q         <= scan_nxt;
				samples_left_q <= mhd_pkg::SL_W'(mhd_pkg::SAMPLES_PER_READ);
				run_min_q      <= mhd_pkg::MIN_RESET;
			end else begin
				samples_left_q <= samples_left_q - 1'b1;
				run_min_q      <= min_new;
			end
		end
	end

	// ------------------------------------------------------------------
	// per-channel memories: thresholds and confirm counters
	// ------------------------------------------------------------------
	logic [mhd_pkg::CHANNELS-1:0]    thr_vld_q;
	logic [mhd_pkg::CHANNELS-1:0]    conf_vld_q;
	logic [mhd_pkg::THR_W-1:0]       thr_rd_s1;
	logic [mhd_pkg::CF_W-1:0]        conf_rd_s1;
	logic                            conf_we;
	logic [mhd_pkg::CF_W-1:0]        conf_new;
	logic [mhd_pkg::CH_AW-1:0]       ch_s1;

	mhd_ram #(
		.WIDTH (mhd_pkg::THR_W),
		.DEPTH (mhd_pkg::CHANNELS)
	) u_thr_ram (
		.clk   (clk),
		.we    (thr_we),
		.waddr (in_data.channel[mhd_pkg::CH_AW-1:0]),
		.wdata ({in_data.high_threshold, in_data.low_threshold}),
		.re    (smp_acc),
		.raddr (scan_q),
		.rdata (thr_rd_s1)
	);

	mhd_ram #(
		.WIDTH (mhd_pkg::CF_W),
		.DEPTH (mhd_pkg::CHANNELS)
	) u_conf_ram (
		.clk   (clk),
		.we    (conf_we),
		.waddr (ch_s1),
		.wdata (conf_new),
		.re    (smp_acc),
		.raddr (scan_q),
		.rdata (conf_rd_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_vld_q  <= '0;
			conf_vld_q <= '0;
		end else begin
			if (thr_we) begin
				thr_vld_q[in_data.channel[mhd_pkg::CH_AW-1:0]] <= 1'b1;
			end
			if (conf_we) begin
				conf_vld_q[ch_s1] <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// stage 1: judge
	// ------------------------------------------------------------------
	logic                            complete_s1;
	logic [mhd_pkg::SAMPLE_BITS-1:0] raw_s1;
	logic [mhd_pkg::DIR_W-1:0]       dir_s1;
	logic [mhd_pkg::CH_AW-1:0]       next_s1;
	logic                            thr_ok_s1;
	logic                            conf_ok_s1;
	logic                            fwd_s1;
	logic [mhd_pkg::CF_W-1:0]        fwd_conf_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (smp_acc) begin
			s1_vld_q <= 1'b1;
		end else if (s1_adv) begin
			s1_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (smp_acc) begin
			complete_s1 <= last_smp;
			raw_s1      <= last_smp ? min_new : '0;
			dir_s1      <= in_data.direction;
			ch_s1       <= scan_q;
			next_s1     <= last_smp ? scan_nxt : scan_q;
			thr_ok_s1   <= thr_vld_q[scan_q];
			conf_ok_s1  <= conf_vld_q[scan_q];
			// counter written back this edge for the entry being read
			fwd_s1      <= conf_we && (ch_s1 == scan_q);
			fwd_conf_s1 <= conf_new;
		end
	end

	logic [mhd_pkg::SAMPLE_BITS-1:0] lo_thr;
	logic [mhd_pkg::SAMPLE_BITS-1:0] hi_thr;
	logic [mhd_pkg::CF_W-1:0]        conf_cur;
	logic [mhd_pkg::CHANNELS-1:0]    held_q;
	logic [mhd_pkg::CHANNELS-1:0]    held_new;
	logic                            held_cur;
	logic                            held_bit;
	logic                            below;
	logic                            above;
	logic                            judge;
	logic                            want;
	logic [mhd_pkg::MASK_W-1:0]      dir_mask;
	logic                            blocked;

	assign lo_thr   = thr_ok_s1 ? thr_rd_s1[mhd_pkg::SAMPLE_BITS-1:0] : '0;
	assign hi_thr   = thr_ok_s1 ? thr_rd_s1[mhd_pkg::THR_W-1:mhd_pkg::SAMPLE_BITS] : '0;
	assign conf_cur = fwd_s1 ? fwd_conf_s1
	                  : (conf_ok_s1 ? conf_rd_s1 : mhd_pkg::CF_W'(mhd_pkg::CONFIRM_COUNT));
	assign held_cur = held_q[ch_s1];

	// low test first: below low reads clear, even with crossed thresholds
	assign below = raw_s1 < lo_thr;
	assign above = raw_s1 > hi_thr;
	assign judge = complete_s1 && (below || above);
	assign want  = !below;

	always_comb begin
		held_bit = held_cur;
		conf_new = mhd_pkg::CF_W'(mhd_pkg::CONFIRM_COUNT);
		if (held_cur != want) begin
			if (conf_cur <= mhd_pkg::CF_W'(1)) begin
				held_bit = want;
			end else begin
				conf_new = conf_cur - 1'b1;
			end
		end
		if (!judge) begin
			held_bit = held_cur;
		end
		held_new        = held_q;
		held_new[ch_s1] = held_bit;
	end

	assign conf_we = s1_adv && judge;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (s1_adv) begin
			held_q <= held_new;
		end
	end

	always_comb begin
		case (dir_s1)
			mhd_pkg::DIR_FWD:  dir_mask = front_mask_q;
			mhd_pkg::DIR_BACK: dir_mask = back_mask_q;
			default:           dir_mask = '0;
		endcase
	end

	assign blocked = |(dir_mask[mhd_pkg::CHANNELS-1:0] & held_new);

	// ------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------
	mhd_pkg::out_item_t out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_adv) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_data_q.complete     <= complete_s1;
			out_data_q.done_channel <= mhd_pkg::CH_W'(ch_s1);
			out_data_q.raw_min      <= raw_s1;
			out_data_q.detected     <= held_bit;
			out_data_q.path_blocked <= blocked;
			out_data_q.next_channel <= mhd_pkg::CH_W'(next_s1);
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_data_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_conf_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		conf_we |-> conf_new != '0)
		else $error("confirm counter written as zero");

	a_samples_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		samples_left_q != '0)
		else $error("samples_left reached zero");

	a_held_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!(s1_adv && complete_s1) |=> $stable(held_q))
		else $error("held state changed without a completed reading");

	a_held_one_bit: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> $countones(held_q ^ $past(held_q)) <= 1)
		else $error("more than one held state changed at once");

	a_adv_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> out_vld_q && (out_data_q.done_channel == mhd_pkg::CH_W'($past(ch_s1))))
		else $error("judged item did not reach the output register");

endmodule

### src/mhd_ram.sv
// ----------------------------------------------------------------------------
// mhd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mhd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic                                         re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read returns old data on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### sim/multichannel_hysteresis_debounce_test.sv
// ----------------------------------------------------------------------------
// multichannel_hysteresis_debounce_test
// Self-checking bench for the round-robin hysteresis and debounce scanner.
// ----------------------------------------------------------------------------
// A shadow model of the scanner is updated at each input transfer. It holds
// the running minimum, the threshold tables, the held states and the confirm
// counters, and it queues the reading that each sample should produce. A
// checker compares every output transfer with the oldest queued reading.
// Directed items cover reset defaults, crossed and extreme thresholds and
// all direction codes. Random phases then run mostly well-formed sensor traces
// with a per-channel lean, under several mask settings, with random idling
// on both sides and a final phase at full rate.
// ----------------------------------------------------------------------------
module multichannel_hysteresis_debounce_test;

	localparam int ITEM_W = $bits(mhd_pkg::in_item_t);
	// direction code with no meaning; must read as not blocked
	localparam logic [mhd_pkg::DIR_W-1:0] DIR_SPARE = 2'd3;

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_stall;
	mhd_pkg::in_item_t            in_data;
	logic                         out_valid;
	logic                         out_stall;
	mhd_pkg::out_item_t           out_data;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [mhd_pkg::PADDR_W-1:0]  paddr;
	logic [mhd_pkg::PDATA_W-1:0]  pwdata;
	logic [mhd_pkg::PDATA_W-1:0]  prdata;
	logic                         pready;

	multichannel_hysteresis_debounce u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// shadow copy of the scanner state
	logic [mhd_pkg::MASK_W-1:0]      shadow_front;
	logic [mhd_pkg::MASK_W-1:0]      shadow_back;
	logic [mhd_pkg::CH_W-1:0]        scan_ch;
	int unsigned                     samples_to_go;
	logic [mhd_pkg::SAMPLE_BITS-1:0] run_min;
	logic [mhd_pkg::SAMPLE_BITS-1:0] raw_tab  [mhd_pkg::CHANNELS];
	logic [mhd_pkg::SAMPLE_BITS-1:0] low_tab  [mhd_pkg::CHANNELS];
	logic [mhd_pkg::SAMPLE_BITS-1:0] high_tab [mhd_pkg::CHANNELS];
	logic                            held     [mhd_pkg::CHANNELS];
	int unsigned                     confirm  [mhd_pkg::CHANNELS];

	mhd_pkg::out_item_t pending_readings[$];
	int unsigned        mismatch_count;

	// percent idling: gap_pct per input transfer, stall_pct per falling edge
	int unsigned gap_pct;
	int unsigned stall_pct;
	int unsigned stall_run;

	// stimulus bias: 1 = the channel is being pushed towards obstacle
	logic lean [mhd_pkg::CHANNELS];

	// ------------------------------------------------------------------------
	// clock and timeout
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("FAILED: results differ");
		$finish;
	end

	// ------------------------------------------------------------------------
	// shadow model
	// ------------------------------------------------------------------------
	function automatic void reset_shadow();
		shadow_front  = '0;
		shadow_back   = '0;
		scan_ch       = '0;
		samples_to_go = mhd_pkg::SAMPLES_PER_READ;
		run_min       = mhd_pkg::MIN_RESET;
		for (int c = 0; c < mhd_pkg::CHANNELS; c++) begin
			raw_tab[c]  = '0;
			low_tab[c]  = '0;
			high_tab[c] = '0;
			held[c]     = 1'b0;
			confirm[c]  = mhd_pkg::CONFIRM_COUNT;
			lean[c]     = 1'b0;
		end
	endfunction

	// hysteresis plus debounce on the freshly stored raw value
	function automatic void judge_reading(input logic [mhd_pkg::CH_W-1:0] ch);
		logic want;
		if (raw_tab[ch] < low_tab[ch])
			want = 1'b0;
		else if (raw_tab[ch] > high_tab[ch])
			want = 1'b1;
		else
			return;	// between thresholds: state and counter untouched
		if (held[ch] == want) begin
			confirm[ch] = mhd_pkg::CONFIRM_COUNT;
		end else if (confirm[ch] <= 1) begin
			held[ch]    = want;
			confirm[ch] = mhd_pkg::CONFIRM_COUNT;
		end else begin
			confirm[ch] = confirm[ch] - 1;
		end
	endfunction

	function automatic logic path_blocked_for(input logic [mhd_pkg::DIR_W-1:0] dir);
		logic [mhd_pkg::MASK_W-1:0] sel;
		logic                       any;
		any = 1'b0;
		if (dir == mhd_pkg::DIR_FWD)
			sel = shadow_front;
		else if (dir == mhd_pkg::DIR_BACK)
			sel = shadow_back;
		else
			return 1'b0;
		for (int c = 0; c < mhd_pkg::CHANNELS; c++)
			if (sel[c] && held[c])
				any = 1'b1;
		return any;
	endfunction

	// advance the shadow scanner by one accepted transfer
	function automatic void scan_and_judge(input mhd_pkg::in_item_t it);
		mhd_pkg::out_item_t       r;
		logic [mhd_pkg::CH_W-1:0] done;
		if (it.operation == mhd_pkg::OP_THRESH) begin
			if (int'(it.channel) < mhd_pkg::CHANNELS) begin
				low_tab[it.channel]  = it.low_threshold;
				high_tab[it.channel] = it.high_threshold;
			end
			return;
		end
		done = scan_ch;
		r    = '0;
		if (it.sample < run_min)
			run_min = it.sample;
		if (samples_to_go <= 1) begin
			r.complete    = 1'b1;
			r.raw_min     = run_min;
			raw_tab[done] = run_min;
			judge_reading(done);
			scan_ch       = (int'(done) + 1 >= mhd_pkg::CHANNELS) ? '0 : done + 1'b1;
			run_min       = mhd_pkg::MIN_RESET;
			samples_to_go = mhd_pkg::SAMPLES_PER_READ;
		end else begin
			samples_to_go = samples_to_go - 1;
		end
		r.done_channel = done;
		r.detected     = held[done];
		r.path_blocked = path_blocked_for(it.direction);
		r.next_channel = scan_ch;
		pending_readings.push_back(r);
	endfunction

	// ------------------------------------------------------------------------
	// item builders; fields not used by the operation carry noise
	// ------------------------------------------------------------------------
	function automatic mhd_pkg::in_item_t make_sample(input int unsigned value,
	                                                  input logic [mhd_pkg::DIR_W-1:0] dir);
		mhd_pkg::in_item_t it;
		it                = ITEM_W'({$urandom, $urandom});
		it.operation      = mhd_pkg::OP_SAMPLE;
		it.sample         = value[mhd_pkg::SAMPLE_BITS-1:0];
		it.direction      = dir;
		return it;
	endfunction

	function automatic mhd_pkg::in_item_t make_thresh(input int unsigned ch,
	                                                  input int unsigned lo,
	                                                  input int unsigned hi);
		mhd_pkg::in_item_t it;
		it                = ITEM_W'({$urandom, $urandom});
		it.operation      = mhd_pkg::OP_THRESH;
		it.channel        = ch[mhd_pkg::CH_W-1:0];
		it.low_threshold  = lo[mhd_pkg::SAMPLE_BITS-1:0];
		it.high_threshold = hi[mhd_pkg::SAMPLE_BITS-1:0];
		return it;
	endfunction

	// Mostly a plausible sensor trace: thresholds with a proper dead band and
	// samples well clear of it on the side the channel currently leans to,
	// so the debounce counters actually run out. The rest is noise.
	function automatic mhd_pkg::in_item_t random_item();
		int unsigned pick;
		int unsigned lo;
		int unsigned hi;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			if (pick < 7) begin
				lo = $urandom_range(250, 450);
				hi = $urandom_range(550, 750);
			end else if (pick < 8) begin
				lo = $urandom_range(600, 1023);	// crossed pair
				hi = $urandom_range(0, 400);
			end else begin
				lo = $urandom_range(0, 1023);
				hi = $urandom_range(0, 1023);
			end
			return make_thresh($urandom_range(0, 7), lo, hi);
		end
		if ($urandom_range(0, 5) == 0)
			lean[scan_ch] = ~lean[scan_ch];
		if (pick >= 88)
			return make_sample($urandom_range(0, 1023),
			                   mhd_pkg::DIR_W'($urandom_range(0, 3)));
		if (lean[scan_ch])
			return make_sample($urandom_range(751, 1023),
			                   mhd_pkg::DIR_W'($urandom_range(0, 3)));
		return make_sample($urandom_range(0, 249), mhd_pkg::DIR_W'($urandom_range(0, 3)));
	endfunction

	// ------------------------------------------------------------------------
	// transfer and register access tasks; all start and end at a falling edge
	// ------------------------------------------------------------------------
	task automatic send_item(input mhd_pkg::in_item_t it);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data  = it;
		do @(posedge clk); while (in_stall);
		scan_and_judge(it);
		@(negedge clk);
	endtask

	// drain: wait for every reading, then let a trailing threshold load settle
	task automatic wait_idle();
		in_valid = 1'b0;
		while (pending_readings.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic idx,
	                          input logic [mhd_pkg::PDATA_W-1:0] wdata,
	                          output logic [mhd_pkg::PDATA_W-1:0] rdata);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = wr;
		paddr   = mhd_pkg::PADDR_W'(idx) << mhd_pkg::REG_SEL_BIT;
		pwdata  = wdata;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		if (wr) begin
			if (idx == mhd_pkg::REG_FRONT)
				shadow_front = wdata[mhd_pkg::MASK_W-1:0];
			else
				shadow_back = wdata[mhd_pkg::MASK_W-1:0];
		end
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// write one mask (upper data bits carry noise) and read it back
	task automatic set_mask(input logic idx, input logic [mhd_pkg::MASK_W-1:0] value);
		logic [mhd_pkg::PDATA_W-1:0] dummy;
		logic [mhd_pkg::PDATA_W-1:0] back;
		apb_access(1'b1, idx,
		           {(mhd_pkg::PDATA_W - mhd_pkg::MASK_W)'($urandom), value}, dummy);
		apb_access(1'b0, idx, '0, back);
		if (back[mhd_pkg::MASK_W-1:0] !== value) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("register %0d read back %h, wrote %h", idx,
				         back[mhd_pkg::MASK_W-1:0], value);
		end
	endtask

	// ------------------------------------------------------------------------
	// output side: random stall bursts, checker against the queued readings
	// ------------------------------------------------------------------------
	initial begin
		out_stall = 1'b0;
		stall_run = 0;
		forever begin
			@(negedge clk);
			if (stall_run != 0) begin
				out_stall = 1'b1;
				stall_run--;
			end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				out_stall = 1'b1;
				stall_run = $urandom_range(0, 3);
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	mhd_pkg::out_item_t want;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_readings.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: output transfer with nothing pending: %p", $realtime,
					         out_data);
			end else begin
				want = pending_readings.pop_front();
				if (out_data.complete     !== want.complete     ||
				    out_data.done_channel !== want.done_channel ||
				    out_data.raw_min      !== want.raw_min      ||
				    out_data.detected     !== want.detected     ||
				    out_data.path_blocked !== want.path_blocked ||
				    out_data.next_channel !== want.next_channel) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: reading mismatch, expected %p, got %p",
						         $realtime, want, out_data);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// reset defaults: zero thresholds and masks, counters at CONFIRM_COUNT
	task automatic test_after_reset();
		gap_pct   = 0;
		stall_pct = 0;
		send_item(make_sample(1023, mhd_pkg::DIR_FWD));
		send_item(make_sample(1023, mhd_pkg::DIR_BACK));
		send_item(make_sample(0, mhd_pkg::DIR_NONE));
		send_item(make_sample(0, DIR_SPARE));
		wait_idle();
	endtask

	// crossed and extreme thresholds, agreement reload, all direction codes;
	// the scan resumes at ch2 after the reset test
	task automatic test_threshold_cases();
		set_mask(mhd_pkg::REG_FRONT, 8'hFF);
		set_mask(mhd_pkg::REG_BACK, 8'h00);
		send_item(make_thresh(2, 100, 900));
		send_item(make_thresh(3, 800, 200));	// crossed
		send_item(make_thresh(4, 0, 1023));	// never leaves its state
		send_item(make_thresh(5, 1023, 0));	// crossed at the extremes
		// ch2 above high: first step of the debounce count
		send_item(make_sample(1023, mhd_pkg::DIR_FWD));
		send_item(make_sample(1023, mhd_pkg::DIR_FWD));
		// ch3 at 500: crossed pair reads clear since low test goes first
		send_item(make_sample(500, mhd_pkg::DIR_BACK));
		send_item(make_sample(700, mhd_pkg::DIR_NONE));
		// ch4 between: held
		send_item(make_sample(1000, DIR_SPARE));
		send_item(make_sample(1023, mhd_pkg::DIR_FWD));
		// ch5: below low wins
		send_item(make_sample(0, mhd_pkg::DIR_FWD));
		send_item(make_sample(1023, mhd_pkg::DIR_BACK));
		// ch6, ch7 on reset thresholds; ch0 then confirms obstacle
		send_item(make_sample(300, mhd_pkg::DIR_FWD));
		send_item(make_sample(512, mhd_pkg::DIR_FWD));
		send_item(make_sample(1, mhd_pkg::DIR_BACK));
		send_item(make_sample(1022, mhd_pkg::DIR_NONE));
		send_item(make_sample(511, mhd_pkg::DIR_FWD));
		send_item(make_sample(513, DIR_SPARE));
		wait_idle();
	endtask

	task automatic test_random_scan(input int n, input logic [mhd_pkg::MASK_W-1:0] fm,
	                                input logic [mhd_pkg::MASK_W-1:0] bm,
	                                input int unsigned gap, input int unsigned stall);
		set_mask(mhd_pkg::REG_FRONT, fm);
		set_mask(mhd_pkg::REG_BACK, bm);
		gap_pct   = gap;
		stall_pct = stall;
		for (int i = 0; i < n; i++)
			send_item(random_item());
		wait_idle();
	endtask

	// ------------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------------
	initial begin
		int unsigned spin;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		in_data        = '0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		gap_pct        = 0;
		stall_pct      = 0;
		mismatch_count = 0;
		reset_shadow();
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_after_reset();
		test_threshold_cases();
		test_random_scan(282, 8'hFF, 8'hFF, 25, 25);
		test_random_scan(282, 8'h00, 8'h00, 10, 40);
		test_random_scan(282, mhd_pkg::MASK_W'($urandom), mhd_pkg::MASK_W'($urandom),
		                 35, 10);
		test_random_scan(282, 8'hA5, 8'h5A, 0, 0);	// full rate, no idling

		spin = 0;
		while (pending_readings.size() != 0 && spin < 2000) begin
			@(negedge clk);
			spin++;
		end
		repeat (8) @(negedge clk);
		if (pending_readings.size() != 0) begin
			mismatch_count += pending_readings.size();
			$display("%0d readings never arrived", pending_readings.size());
		end
		if (mismatch_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
